// ----- rtl/multi_key_click_event_detector_unit_defines.svh -----
// ----------------------------------------------------------------------------
// multi key click event detector assertion macros
// clocked property helpers used by the checker file
// ----------------------------------------------------------------------------
`ifndef MULTI_KEY_CLICK_EVENT_DETECTOR_UNIT_DEFINES_SVH
`define MULTI_KEY_CLICK_EVENT_DETECTOR_UNIT_DEFINES_SVH

// same-cycle implication
`define MKCED_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define MKCED_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/mkced_pkg.sv -----
// ----------------------------------------------------------------------------
// mkced_pkg
// shared types and codes of the multi key click event detector
// ----------------------------------------------------------------------------
package mkced_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_DEBOUNCE = 2'd1,
    MODE_PRESSED  = 2'd2,
    MODE_WAIT     = 2'd3
  } mode_t;

  localparam logic [1:0] EV_SINGLE = 2'd0;
  localparam logic [1:0] EV_DOUBLE = 2'd1;
  localparam logic [1:0] EV_LONG   = 2'd2;
  localparam logic [1:0] EV_NONE   = 2'd3;

  localparam logic [1:0] CFG_DEBOUNCE   = 2'd0;
  localparam logic [1:0] CFG_LONG_PRESS = 2'd1;
  localparam logic [1:0] CFG_DOUBLE_GAP = 2'd2;

  localparam logic [15:0] DEBOUNCE_RESET   = 16'd20;
  localparam logic [15:0] LONG_PRESS_RESET = 16'd1000;
  localparam logic [15:0] DOUBLE_GAP_RESET = 16'd300;

endpackage

// ----- rtl/multi_key_click_event_detector_unit.sv -----
// ----------------------------------------------------------------------------
// multi_key_click_event_detector_unit
// per-key debounce and single, double and long press detection over a key
// state memory, one event request per firing key in ascending key order
// ----------------------------------------------------------------------------
// a new tick waits until the sequencer is back in idle: each key takes a
// memory read state and an update state, then a flush state follows. an
// output register holding the pending event adds waits while event_stall
// keeps the previous event; the last event of a tick is loaded in the flush
// state once not stalled. reset clears the key state through per-entry valid
// bits at once and loads the default thresholds; no clearing pass is needed
module multi_key_click_event_detector_unit #(
  parameter int KEY_COUNT    = 10,
  parameter int ELAPSED_BITS = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        tick_valid,
  output logic        tick_stall,
  input  logic [15:0] pressed_keys,
  output logic        event_valid,
  input  logic        event_stall,
  output logic [3:0]  key_index,
  output logic [1:0]  event_kind,
  output logic        last,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import mkced_pkg::*;

  localparam int KW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = '1;

  typedef struct packed {
    mode_t                   mode;
    logic [ELAPSED_BITS-1:0] elapsed;
    logic [1:0]              clicks;
    logic                    long_done;
  } word_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_EVAL  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  state_t                state;
  logic [KW-1:0]         key;
  logic [KEY_COUNT-1:0]  keys;
  logic [KEY_COUNT-1:0]  entry_valid;
  word_t                 mem [KEY_COUNT];
  word_t                 rd_word;
  logic                  rd_hit;
  logic [15:0]           debounce_ticks;
  logic [15:0]           long_press_ticks;
  logic [15:0]           double_gap_ticks;
  logic                  pend_valid;
  logic [KW-1:0]         pend_key;
  logic [1:0]            pend_kind;

  word_t                   cur;
  word_t                   upd;
  logic [1:0]              ev;
  logic [1:0]              clicks_inc;
  logic [ELAPSED_BITS-1:0] el_inc;
  logic [ELAPSED_BITS-1:0] deb_th;
  logic [ELAPSED_BITS-1:0] long_th;
  logic [ELAPSED_BITS-1:0] gap_th;
  logic                    down;
  logic                    ev_hit;
  logic                    out_busy;
  logic                    eval_hold;
  logic                    eval_go;
  logic                    last_key;
  logic                    out_load;

  assign deb_th   = {{(ELAPSED_BITS-16){1'b0}}, debounce_ticks};
  assign long_th  = {{(ELAPSED_BITS-16){1'b0}}, long_press_ticks};
  assign gap_th   = {{(ELAPSED_BITS-16){1'b0}}, double_gap_ticks};
  assign cur      = rd_hit ? rd_word : word_t'('0);
  assign down     = keys[key];
  assign last_key = (key == KW'(KEY_COUNT - 1));

  // per-key state update
  always_comb begin
    el_inc     = cur.elapsed;
    clicks_inc = cur.clicks + 2'd1;
    if (cur.mode != MODE_IDLE && cur.elapsed != ELAPSED_MAX) begin
      el_inc = cur.elapsed + 1'b1;
    end
    upd         = cur;
    upd.elapsed = el_inc;
    ev          = EV_NONE;
    unique case (cur.mode)
      MODE_IDLE: begin
        if (down) begin
          upd.elapsed   = '0;
          upd.mode      = MODE_DEBOUNCE;
          upd.long_done = 1'b0;
        end
      end
      MODE_DEBOUNCE: begin
        if (!down) begin
          upd.mode = MODE_IDLE;
        end else if (el_inc >= deb_th) begin
          upd.mode = MODE_PRESSED;
        end
      end
      MODE_PRESSED: begin
        if (!down) begin
          if (el_inc >= long_th) begin
            if (!cur.long_done) begin
              ev = EV_LONG;
            end
            upd.clicks = 2'd0;
            upd.mode   = MODE_IDLE;
          end else if (clicks_inc == 2'd2) begin
            ev         = EV_DOUBLE;
            upd.clicks = 2'd0;
            upd.mode   = MODE_IDLE;
          end else begin
            upd.clicks  = clicks_inc;
            upd.mode    = MODE_WAIT;
            upd.elapsed = '0;
          end
          upd.long_done = 1'b0;
        end else if (el_inc >= long_th && !cur.long_done) begin
          ev            = EV_LONG;
          upd.long_done = 1'b1;
        end
      end
      MODE_WAIT: begin
        if (down) begin
          upd.elapsed   = '0;
          upd.mode      = MODE_DEBOUNCE;
          upd.long_done = 1'b0;
        end else if (el_inc > gap_th) begin
          if (cur.clicks == 2'd1) begin
            ev = EV_SINGLE;
          end
          upd.clicks = 2'd0;
          upd.mode   = MODE_IDLE;
        end
      end
      default: upd = cur;
    endcase
  end

  assign ev_hit     = (ev != EV_NONE);
  assign out_busy   = event_valid && event_stall;
  assign eval_hold  = ev_hit && pend_valid && out_busy;
  assign eval_go    = (state == S_EVAL) && !eval_hold;
  assign tick_stall = (state != S_IDLE);
  assign out_load   = (eval_go && ev_hit && pend_valid) ||
                      ((state == S_FLUSH) && pend_valid && !out_busy);

  // key state memory
  always_ff @(posedge clk) begin
    if (eval_go) begin
      mem[key] <= upd;
    end
    if (state == S_READ) begin
      rd_word <= mem[key];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_hit      <= 1'b0;
    end else begin
      if (eval_go) begin
        entry_valid[key] <= 1'b1;
      end
      if (state == S_READ) begin
        rd_hit <= entry_valid[key];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks   <= DEBOUNCE_RESET;
      long_press_ticks <= LONG_PRESS_RESET;
      double_gap_ticks <= DOUBLE_GAP_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_DEBOUNCE:   debounce_ticks   <= cfg_data;
        CFG_LONG_PRESS: long_press_ticks <= cfg_data;
        CFG_DOUBLE_GAP: double_gap_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer, pending event and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      key         <= '0;
      pend_valid  <= 1'b0;
      event_valid <= 1'b0;
    end else begin
      if (out_load) begin
        event_valid <= 1'b1;
      end else if (event_valid && !event_stall) begin
        event_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (tick_valid) begin
            keys  <= pressed_keys[KEY_COUNT-1:0];
            key   <= '0;
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (!eval_hold) begin
            if (ev_hit) begin
              if (pend_valid) begin
                key_index  <= 4'(pend_key);
                event_kind <= pend_kind;
                last       <= 1'b0;
              end
              pend_valid <= 1'b1;
              pend_key   <= key;
              pend_kind  <= ev;
            end
            if (last_key) begin
              state <= S_FLUSH;
            end else begin
              key   <= key + 1'b1;
              state <= S_READ;
            end
          end
        end
        S_FLUSH: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (!out_busy) begin
            key_index  <= 4'(pend_key);
            event_kind <= pend_kind;
            last       <= 1'b1;
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/mkced_checker.sv -----
// ----------------------------------------------------------------------------
// mkced_checker
// port-level checks of the multi key click event detector
// ----------------------------------------------------------------------------
`include "multi_key_click_event_detector_unit_defines.svh"

module mkced_checker #(
  parameter int KEY_COUNT = 10
) (
  input logic       clk,
  input logic       rst,
  input logic       tick_valid,
  input logic       tick_stall,
  input logic       event_valid,
  input logic       event_stall,
  input logic [3:0] key_index,
  input logic [1:0] event_kind,
  input logic       last
);
  import mkced_pkg::*;

  `MKCED_ASSERT_NEXT(a_out_hold, clk, rst, event_valid && event_stall, event_valid && $stable(key_index) && $stable(event_kind) && $stable(last))
  `MKCED_ASSERT_NEXT(a_busy_after_tick, clk, rst, tick_valid && !tick_stall, tick_stall)
  `MKCED_ASSERT_NOW(a_kind_legal, clk, rst, event_valid, event_kind != EV_NONE)
  `MKCED_ASSERT_NOW(a_key_range, clk, rst, event_valid, {1'b0, key_index} < 5'(KEY_COUNT))

endmodule

bind multi_key_click_event_detector_unit mkced_checker #(.KEY_COUNT(KEY_COUNT)) u_mkced_checker (
  .clk         (clk),
  .rst         (rst),
  .tick_valid  (tick_valid),
  .tick_stall  (tick_stall),
  .event_valid (event_valid),
  .event_stall (event_stall),
  .key_index   (key_index),
  .event_kind  (event_kind),
  .last        (last)
);
